// File: sv/afr_pkg.sv
// ----------------------------------------------------------------------------
// afr_pkg: shared constants and types of the audio frame ring FIFO
// Sizes, action and statistic codes, and the control/status structs that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package afr_pkg;

  // Ring size; a power of two so that a pointer modulo twice the capacity
  // is the natural wrap of a PTR_W-bit counter.
  localparam int unsigned CAPACITY_FRAMES = 1024;
  localparam int unsigned CHANNELS        = 2;
  localparam int unsigned MAX_READ_BURST  = 64;

  localparam int unsigned SLOT_W  = $clog2(CAPACITY_FRAMES);
  localparam int unsigned PTR_W   = SLOT_W + 1;
  localparam int unsigned RD_W    = $clog2(MAX_READ_BURST + 1);
  localparam int unsigned FRAME_W = 32 * CHANNELS;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned SEL_W    = 4;
  localparam int unsigned STAT_W   = 32;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_OPEN   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_FLUSH  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_UNDER  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_STATUS = 3'd5;

  // Statistic counters, in selector order after the fill level
  localparam int unsigned ST_CALLBACKS  = 0;
  localparam int unsigned ST_PRODUCED   = 1;
  localparam int unsigned ST_CONSUMED   = 2;
  localparam int unsigned ST_DROPPED    = 3;
  localparam int unsigned ST_OVERRUNS   = 4;
  localparam int unsigned ST_UNDERRUNS  = 5;
  localparam int unsigned ST_HIGH_WATER = 6;
  localparam int unsigned ST_STALE      = 7;
  localparam int unsigned ST_COUNT      = 8;
  localparam int unsigned ST_IDX_W      = $clog2(ST_COUNT);

  localparam logic [SEL_W-1:0] SEL_FILL = 4'd0;
  localparam logic [SEL_W-1:0] SEL_LAST = 4'd8;

  // Controller to datapath
  typedef struct packed {
    logic take;      // input request accepted this cycle
    logic rd_issue;  // present the next read slot to the RAM
    logic rd_load;   // load RAM read data into the output register
  } afr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register is empty or drains this cycle
    logic rd_burst;  // the offered request is a read returning frames
    logic rd_done;   // no frames left to issue in the current read
  } afr_sts_t;

endpackage

// File: sv/afr_if.sv
// ----------------------------------------------------------------------------
// afr_in_if / afr_out_if: valid/ready channels of the ring FIFO
// Input requests and result items, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface afr_in_if
  import afr_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [COUNT_W-1:0]  burst_count;
  logic [DATA_W-1:0]   frame_data;
  logic [SEL_W-1:0]    stat_select;

  modport source (output valid, action, burst_count, frame_data, stat_select,
                  input ready);
  modport sink (input valid, action, burst_count, frame_data, stat_select,
                output ready);
endinterface

interface afr_out_if
  import afr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              frame_valid;
  logic [DATA_W-1:0] read_frame;
  logic              last_result;
  logic [STAT_W-1:0] stat_value;

  modport source (output valid, accepted, frame_valid, read_frame, last_result,
                  stat_value, input ready);
  modport sink (input valid, accepted, frame_valid, read_frame, last_result,
                stat_value, output ready);
endinterface

// File: sv/afr_ram.sv
// ----------------------------------------------------------------------------
// afr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module afr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/afr_ctrl.sv
// ----------------------------------------------------------------------------
// afr_ctrl: request sequencer of the ring FIFO
// Accepts requests and steps a read burst through the RAM, one frame at a
// time: issue the slot, then load the read data into the output register.
// ----------------------------------------------------------------------------
module afr_ctrl
  import afr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  afr_sts_t sts_i,
  output afr_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_LOAD  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = sts_i.out_free;
        cmd_o.take = in_valid_i && sts_i.out_free;
        if (cmd_o.take && sts_i.rd_burst) begin
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        // wait until the output register is sure to be empty at load time
        if (sts_i.out_free) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.rd_load = 1'b1;
        state_d       = sts_i.rd_done ? S_IDLE : S_ISSUE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_issue_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_issue |=> cmd_o.rd_load)
    else $error("read issue not followed by a load");
  a_no_take_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_issue || cmd_o.rd_load) |-> !in_ready_o)
    else $error("request accepted during a read burst");
`endif

endmodule

// File: sv/afr_dp.sv
// ----------------------------------------------------------------------------
// afr_dp: datapath of the ring FIFO
// Pointers, burst tracking, statistic counters, frame RAM and output register.
// ----------------------------------------------------------------------------
module afr_dp
  import afr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  afr_cmd_t            cmd_i,
  output afr_sts_t            sts_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [COUNT_W-1:0]  burst_count_i,
  input  logic [DATA_W-1:0]   frame_data_i,
  input  logic [SEL_W-1:0]    stat_select_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                accepted_o,
  output logic                frame_valid_o,
  output logic [DATA_W-1:0]   read_frame_o,
  output logic                last_result_o,
  output logic [STAT_W-1:0]   stat_value_o
);

  logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic              bo_q, bo_d;
  logic [PTR_W-1:0]  bt_q, bt_d, bw_q, bw_d;
  logic [STAT_W-1:0] stat_q [ST_COUNT];
  logic [STAT_W-1:0] stat_d [ST_COUNT];
  logic [RD_W-1:0]   rd_left_q, rd_left_d;
  logic [SLOT_W-1:0] rd_slot_q, rd_slot_d;

  logic              out_valid_q;
  logic              acc_q, fvalid_q, last_q;
  logic [DATA_W-1:0] frame_q;
  logic [STAT_W-1:0] sval_q;

  logic [PTR_W-1:0]  used, free, c_used, bw_next, hw, wr_ptr;
  logic [RD_W-1:0]   rd_n;
  logic              res_acc;
  logic [STAT_W-1:0] res_stat;
  logic              ram_we;
  logic [FRAME_W-1:0] ram_rdata;

  assign used    = PTR_W'(wp_q - rp_q);
  assign free    = PTR_W'(CAPACITY_FRAMES) - used;
  assign c_used  = (burst_count_i < COUNT_W'(used)) ? burst_count_i[PTR_W-1:0] : used;
  assign rd_n    = (c_used > PTR_W'(MAX_READ_BURST)) ? RD_W'(MAX_READ_BURST)
                                                     : c_used[RD_W-1:0];
  assign bw_next = bw_q + PTR_W'(1);
  assign hw      = used + bt_q;
  assign wr_ptr  = wp_q + bw_q;

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.rd_burst = (action_i == ACT_READ) && (rd_n != '0);
  assign sts_o.rd_done  = (rd_left_q == '0);

  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    bo_d      = bo_q;
    bt_d      = bt_q;
    bw_d      = bw_q;
    stat_d    = stat_q;
    rd_left_d = rd_left_q;
    rd_slot_d = rd_slot_q;
    res_acc   = 1'b0;
    res_stat  = '0;
    ram_we    = 1'b0;

    if (cmd_i.take) begin
      unique case (action_i)
        ACT_OPEN: begin
          stat_d[ST_CALLBACKS] = stat_q[ST_CALLBACKS] + STAT_W'(1);
          bo_d = 1'b0;
          if (burst_count_i == '0) begin
            res_acc = 1'b1;
          end else if (burst_count_i > COUNT_W'(free)) begin
            stat_d[ST_DROPPED]  = stat_q[ST_DROPPED] + burst_count_i;
            stat_d[ST_OVERRUNS] = stat_q[ST_OVERRUNS] + STAT_W'(1);
          end else begin
            bo_d    = 1'b1;
            bt_d    = burst_count_i[PTR_W-1:0];
            bw_d    = '0;
            res_acc = 1'b1;
          end
        end
        ACT_WRITE: begin
          if (bo_q) begin
            ram_we  = 1'b1;
            res_acc = 1'b1;
            if (bw_next >= bt_q) begin
              wp_d = wp_q + bt_q;
              stat_d[ST_PRODUCED] = stat_q[ST_PRODUCED] + STAT_W'(bt_q);
              if (STAT_W'(hw) > stat_q[ST_HIGH_WATER]) begin
                stat_d[ST_HIGH_WATER] = STAT_W'(hw);
              end
              bo_d = 1'b0;
              bt_d = '0;
              bw_d = '0;
            end else begin
              bw_d = bw_next;
            end
          end
        end
        ACT_READ: begin
          if (rd_n != '0) begin
            rd_left_d = rd_n;
            rd_slot_d = rp_q[SLOT_W-1:0];
            rp_d      = rp_q + PTR_W'(rd_n);
            stat_d[ST_CONSUMED] = stat_q[ST_CONSUMED] + STAT_W'(rd_n);
          end
        end
        ACT_FLUSH: begin
          stat_d[ST_STALE] = stat_q[ST_STALE] + STAT_W'(used);
          rp_d     = wp_q;
          res_stat = STAT_W'(used);
        end
        ACT_UNDER: begin
          stat_d[ST_UNDERRUNS] = stat_q[ST_UNDERRUNS] + STAT_W'(1);
        end
        ACT_STATUS: begin
          if (stat_select_i == SEL_FILL) begin
            res_stat = STAT_W'(used);
          end else if (stat_select_i <= SEL_LAST) begin
            res_stat = stat_q[ST_IDX_W'(stat_select_i - SEL_W'(1))];
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.rd_issue) begin
      rd_left_d = rd_left_q - RD_W'(1);
      rd_slot_d = rd_slot_q + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      bo_q        <= 1'b0;
      bt_q        <= '0;
      bw_q        <= '0;
      rd_left_q   <= '0;
      rd_slot_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ST_COUNT; i++) begin
        stat_q[i] <= '0;
      end
    end else begin
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      bo_q      <= bo_d;
      bt_q      <= bt_d;
      bw_q      <= bw_d;
      rd_left_q <= rd_left_d;
      rd_slot_q <= rd_slot_d;
      stat_q    <= stat_d;
      if ((cmd_i.take && !sts_o.rd_burst) || cmd_i.rd_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload: single results on take, ring frames on load
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && !sts_o.rd_burst) begin
      acc_q    <= res_acc;
      fvalid_q <= 1'b0;
      frame_q  <= '0;
      last_q   <= 1'b1;
      sval_q   <= res_stat;
    end else if (cmd_i.rd_load) begin
      acc_q    <= 1'b0;
      fvalid_q <= 1'b1;
      frame_q  <= DATA_W'(ram_rdata);
      last_q   <= (rd_left_q == '0);
      sval_q   <= '0;
    end
  end

  afr_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (CAPACITY_FRAMES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr[SLOT_W-1:0]),
    .wdata_i (frame_data_i[FRAME_W-1:0]),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_slot_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = acc_q;
  assign frame_valid_o = fvalid_q;
  assign read_frame_o  = frame_q;
  assign last_result_o = last_q;
  assign stat_value_o  = sval_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= PTR_W'(CAPACITY_FRAMES))
    else $error("fill level above capacity");
  a_burst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bo_q |-> (bw_q < bt_q) && (PTR_W'(used + bt_q) <= PTR_W'(CAPACITY_FRAMES)))
    else $error("open burst exceeds its admitted space");
`endif

endmodule

// File: sv/audio_frame_ring_fifo_with_stats_unit.sv
// ----------------------------------------------------------------------------
// audio_frame_ring_fifo_with_stats_unit: audio frame ring FIFO with statistics
// Top level joining the request sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries requests: open a write burst, write one frame, read up to a
//   requested number of frames, flush, record an underrun, or read a
//   statistic. out_o returns result items; every request yields one result,
//   except a read that finds frames, which yields one result per frame (at
//   most 64) with last_result set on the final one.
//   Single-result requests: the result appears in the output register in the
//   cycle after the request is accepted, and a new request is taken every
//   cycle as long as the receiver keeps up, so a write burst streams at one
//   frame per cycle.
//   Read requests: each frame is stepped through the frame RAM in turn:
//   present its slot to the RAM, then load its registered read data into the
//   output register; a slot is presented only once the output register can
//   take it. No new request is taken until the last frame of the read is loaded.
//   Reset clears pointers, burst state, counters and the output register;
//   the frame RAM is not cleared (only committed slots are ever read).
//   When the receiver stalls, the held result stays put and input ready
//   drops until the output register can take the next result.
// ----------------------------------------------------------------------------
module audio_frame_ring_fifo_with_stats_unit
  import afr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  afr_in_if.sink    in_i,
  afr_out_if.source out_o
);

  afr_cmd_t cmd;
  afr_sts_t sts;

  // Sequencer: accept requests, step read bursts
  afr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: ring pointers, counters, frame RAM and the result register
  afr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (in_i.action),
    .burst_count_i (in_i.burst_count),
    .frame_data_i  (in_i.frame_data),
    .stat_select_i (in_i.stat_select),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .accepted_o    (out_o.accepted),
    .frame_valid_o (out_o.frame_valid),
    .read_frame_o  (out_o.read_frame),
    .last_result_o (out_o.last_result),
    .stat_value_o  (out_o.stat_value)
  );

endmodule

// File: verif/afr_ring_checker.sv
// ----------------------------------------------------------------------------
// afr_ring_checker: result checker for the audio frame ring FIFO
// Watches both channels, keeps its own copy of the ring, pointers, burst
// state and statistics, and compares every result with the oldest one due.
// ----------------------------------------------------------------------------
module afr_ring_checker
  import afr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  afr_in_if    req_i,
  afr_out_if   rsp_i,
  output int   pending_o,
  output int   fail_count_o
);

  typedef struct packed {
    logic              accepted;
    logic              frame_valid;
    logic [DATA_W-1:0] read_frame;
    logic              last_result;
    logic [STAT_W-1:0] stat_value;
  } ring_result_t;

  localparam logic [COUNT_W-1:0] CAP_FRAMES = COUNT_W'(CAPACITY_FRAMES);
  localparam logic [COUNT_W-1:0] READ_CLAMP = COUNT_W'(MAX_READ_BURST);

  logic [DATA_W-1:0] ring_mem [CAPACITY_FRAMES];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic              burst_on;
  logic [PTR_W-1:0]  burst_len, burst_done;
  logic [STAT_W-1:0] stat_cnt [ST_COUNT];
  ring_result_t      due_results [$];
  ring_result_t      got, want;
  int                fails;

  task automatic queue_result(input logic acc, input logic fv,
                              input logic [DATA_W-1:0] frame, input logic last,
                              input logic [STAT_W-1:0] stat);
    ring_result_t r;
    r.accepted    = acc;
    r.frame_valid = fv;
    r.read_frame  = frame;
    r.last_result = last;
    r.stat_value  = stat;
    due_results.push_back(r);
  endtask

  // Advance the ring state by one request and queue the results it causes.
  task automatic apply_request(input logic [ACTION_W-1:0] act,
                               input logic [COUNT_W-1:0] cnt,
                               input logic [DATA_W-1:0] data,
                               input logic [SEL_W-1:0] sel);
    logic [PTR_W-1:0]   used, at;
    logic [COUNT_W-1:0] take, hw;
    logic [STAT_W-1:0]  v;
    used = wr_ptr - rd_ptr;
    case (act)
      ACT_OPEN: begin
        stat_cnt[ST_CALLBACKS] += 1;
        burst_on = 1'b0;
        if (cnt == '0) begin
          queue_result(1'b1, 1'b0, '0, 1'b1, '0);
        end else if (cnt > CAP_FRAMES - COUNT_W'(used)) begin
          // free space never exceeds the capacity, so one test covers both
          stat_cnt[ST_DROPPED]  += cnt;
          stat_cnt[ST_OVERRUNS] += 1;
          queue_result(1'b0, 1'b0, '0, 1'b1, '0);
        end else begin
          burst_on   = 1'b1;
          burst_len  = PTR_W'(cnt);
          burst_done = '0;
          queue_result(1'b1, 1'b0, '0, 1'b1, '0);
        end
      end
      ACT_WRITE: begin
        if (!burst_on) begin
          queue_result(1'b0, 1'b0, '0, 1'b1, '0);
        end else begin
          at = wr_ptr + burst_done;
          ring_mem[at[SLOT_W-1:0]] = DATA_W'(data[FRAME_W-1:0]);
          burst_done += 1;
          if (burst_done >= burst_len) begin
            hw = COUNT_W'(used) + COUNT_W'(burst_len);
            wr_ptr += burst_len;
            stat_cnt[ST_PRODUCED] += STAT_W'(burst_len);
            if (hw > stat_cnt[ST_HIGH_WATER]) stat_cnt[ST_HIGH_WATER] = hw;
            burst_on   = 1'b0;
            burst_len  = '0;
            burst_done = '0;
          end
          queue_result(1'b1, 1'b0, '0, 1'b1, '0);
        end
      end
      ACT_READ: begin
        take = cnt;
        if (take > COUNT_W'(used)) take = COUNT_W'(used);
        if (take > READ_CLAMP) take = READ_CLAMP;
        if (take == '0) begin
          queue_result(1'b0, 1'b0, '0, 1'b1, '0);
        end else begin
          for (int unsigned k = 0; k < take; k++) begin
            at = rd_ptr + PTR_W'(k);
            queue_result(1'b0, 1'b1, ring_mem[at[SLOT_W-1:0]], k + 1 == take, '0);
          end
          rd_ptr += PTR_W'(take);
          stat_cnt[ST_CONSUMED] += take;
        end
      end
      ACT_FLUSH: begin
        stat_cnt[ST_STALE] += STAT_W'(used);
        rd_ptr = wr_ptr;
        queue_result(1'b0, 1'b0, '0, 1'b1, STAT_W'(used));
      end
      ACT_UNDER: begin
        stat_cnt[ST_UNDERRUNS] += 1;
        queue_result(1'b0, 1'b0, '0, 1'b1, '0);
      end
      ACT_STATUS: begin
        if (sel == SEL_FILL)      v = STAT_W'(used);
        else if (sel <= SEL_LAST) v = stat_cnt[sel - 4'd1];
        else                      v = '0;
        queue_result(1'b0, 1'b0, '0, 1'b1, v);
      end
      default: begin
        queue_result(1'b0, 1'b0, '0, 1'b1, '0);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr     = '0;
      rd_ptr     = '0;
      burst_on   = 1'b0;
      burst_len  = '0;
      burst_done = '0;
      for (int i = 0; i < ST_COUNT; i++) stat_cnt[i] = '0;
      due_results.delete();
      fails = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        apply_request(req_i.action, req_i.burst_count, req_i.frame_data, req_i.stat_select);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        got.accepted    = rsp_i.accepted;
        got.frame_valid = rsp_i.frame_valid;
        got.read_frame  = rsp_i.read_frame;
        got.last_result = rsp_i.last_result;
        got.stat_value  = rsp_i.stat_value;
        if (due_results.size() == 0) begin
          fails++;
          $display("%0t: result with none due: acc=%0b fv=%0b frame=%h last=%0b stat=%0d",
                   $time, got.accepted, got.frame_valid, got.read_frame,
                   got.last_result, got.stat_value);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: mismatch: expected acc=%0b fv=%0b frame=%h last=%0b stat=%0d",
                     $time, want.accepted, want.frame_valid, want.read_frame,
                     want.last_result, want.stat_value);
            $display("%0t:           actual   acc=%0b fv=%0b frame=%h last=%0b stat=%0d",
                     $time, got.accepted, got.frame_valid, got.read_frame,
                     got.last_result, got.stat_value);
          end
        end
      end
      pending_o    <= due_results.size();
      fail_count_o <= fails;
    end
  end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top of the audio frame ring FIFO with statistics
// Drives directed and random requests with random gaps and output stalls,
// probes the free-space limit once, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb;
  import afr_pkg::*;

  localparam int CLK_PERIOD = 10;
  // Watchdog: far beyond the slowest legal run (every result stalled long).
  localparam int RUN_LIMIT  = 100_000_000;
  // Quiet time after the last result: room for a full read burst with margin.
  localparam int DRAIN_CYCLES = 4 * MAX_READ_BURST;
  // Frames stored before probing the free-space limit; enough for a full read.
  localparam int unsigned PROBE_FILL = MAX_READ_BURST + 6;

  // Spare codes the block does not define, which must act as no-ops, and two statistic selectors.
  localparam logic [ACTION_W-1:0] ACT_SPARE_A    = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_B    = 3'd7;
  localparam logic [SEL_W-1:0]    SEL_TOP        = 4'd15;
  localparam logic [SEL_W-1:0]    SEL_HIGH_WATER = SEL_W'(ST_HIGH_WATER + 1);
  localparam logic [SEL_W-1:0]    SEL_STALE      = SEL_W'(ST_STALE + 1);

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   results_pending;
  bit   quiet;  // set to suppress all idling on both sides

  afr_in_if  req_if ();
  afr_out_if rsp_if ();

  audio_frame_ring_fifo_with_stats_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  afr_ring_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .pending_o    (results_pending),
    .fail_count_o (fail_count)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Hard stop in case a result never shows up.
  initial begin : watchdog
    #RUN_LIMIT;
    $display("** audio_frame_ring_fifo_with_stats_unit: FAILED **");
    $finish;
  end

  // Idle length: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] rand_frame();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [SEL_W-1:0] rand_sel();
    return SEL_W'($urandom_range(0, 15));
  endfunction

  // Send one request: idle for a random gap, then hold valid until taken.
  // Lower valid only when a gap follows, so back-to-back requests keep it high.
  task automatic issue(input logic [ACTION_W-1:0] act, input logic [COUNT_W-1:0] cnt,
                       input logic [DATA_W-1:0] data, input logic [SEL_W-1:0] sel);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.action      <= act;
    req_if.burst_count <= cnt;
    req_if.frame_data  <= data;
    req_if.stat_select <= sel;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Drop valid and hold until every predicted result has been returned.
  task automatic wait_all_returned();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  function automatic int unsigned burst_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5)  return 0;
    if (roll < 75) return $urandom_range(1, 8);
    if (roll < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 120);
  endfunction

  function automatic logic [COUNT_W-1:0] read_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5)  return '0;
    if (roll < 70) return $urandom_range(1, 20);
    if (roll < 90) return $urandom_range(21, 100);
    return $urandom();
  endfunction

  // Mostly well-formed write bursts and reads with random content; the rest
  // is flushes, status reads, underruns, oversized opens, stray frames and spare codes.
  task automatic random_traffic(input int unsigned target);
    int unsigned sent_n, roll, len;
    sent_n = 0;
    while (sent_n < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        len = burst_size();
        issue(ACT_OPEN, len, rand_frame(), rand_sel());
        sent_n++;
        for (int unsigned k = 0; k < len; k++) begin
          if ($urandom_range(0, 99) < 3) begin
            // break the burst: flush under it, or leave it pending for the
            // next open to abandon
            if ($urandom_range(0, 1) != 0) begin
              issue(ACT_FLUSH, $urandom(), rand_frame(), rand_sel());
              sent_n++;
            end else begin
              break;
            end
          end
          issue(ACT_WRITE, $urandom(), rand_frame(), rand_sel());
          sent_n++;
        end
      end else if (roll < 70) begin
        issue(ACT_READ, read_size(), rand_frame(), rand_sel());
        sent_n++;
      end else if (roll < 80) begin
        issue(ACT_STATUS, $urandom(), rand_frame(), rand_sel());
        sent_n++;
      end else if (roll < 84) begin
        issue(ACT_FLUSH, $urandom(), rand_frame(), rand_sel());
        sent_n++;
      end else if (roll < 88) begin
        issue(ACT_UNDER, $urandom(), rand_frame(), rand_sel());
        sent_n++;
      end else if (roll < 93) begin
        // oversized open: above the capacity or over the free space
        if ($urandom_range(0, 1) != 0) len = $urandom();
        else len = $urandom_range(CAPACITY_FRAMES - 40, 4 * CAPACITY_FRAMES);
        issue(ACT_OPEN, len, rand_frame(), rand_sel());
        sent_n++;
      end else if (roll < 97) begin
        // stray frame; ignored unless a broken burst is still pending
        issue(ACT_WRITE, $urandom(), rand_frame(), rand_sel());
        sent_n++;
      end else begin
        issue(($urandom_range(0, 1) != 0) ? ACT_SPARE_A : ACT_SPARE_B,
              $urandom(), rand_frame(), rand_sel());
        sent_n++;
      end
    end
  endtask

  // Settle, refill the ring to a known level, then probe the free-space limit
  // from both sides and read back a full clamped burst.
  task automatic probe_limits();
    wait_all_returned();
    quiet = 1'b1;
    issue(ACT_FLUSH, $urandom(), rand_frame(), rand_sel());
    issue(ACT_OPEN, PROBE_FILL, rand_frame(), rand_sel());
    for (int unsigned k = 0; k < PROBE_FILL; k++) begin
      if (k == PROBE_FILL / 2) quiet = 1'b0;
      issue(ACT_WRITE, $urandom(), rand_frame(), rand_sel());
    end
    issue(ACT_STATUS, $urandom(), rand_frame(), SEL_HIGH_WATER);
    // one above the free space, exactly the free space, then the capacity
    issue(ACT_OPEN, CAPACITY_FRAMES - PROBE_FILL + 1, rand_frame(), rand_sel());
    issue(ACT_OPEN, CAPACITY_FRAMES - PROBE_FILL, rand_frame(), rand_sel());
    issue(ACT_OPEN, CAPACITY_FRAMES, rand_frame(), rand_sel());
    // leave a large admitted burst pending under a full read
    issue(ACT_OPEN, CAPACITY_FRAMES - PROBE_FILL, rand_frame(), rand_sel());
    issue(ACT_WRITE, $urandom(), rand_frame(), rand_sel());
    issue(ACT_READ, MAX_READ_BURST, rand_frame(), rand_sel());
    issue(ACT_OPEN, 1, rand_frame(), rand_sel());
    issue(ACT_STATUS, $urandom(), rand_frame(), SEL_FILL);
  endtask

  // Result side: accept for a random stretch, then stall for a random gap.
  initial begin : rsp_sink
    int unsigned hold, gap;
    rsp_if.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hold = $urandom_range(1, 24);
      rsp_if.ready <= 1'b1;
      repeat (hold) @(posedge clk_i);
      gap = pick_gap();
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    quiet              = 1'b0;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.action      = ACT_OPEN;
    req_if.burst_count = '0;
    req_if.frame_data  = '0;
    req_if.stat_select = SEL_FILL;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty ring, zero burst, stray frame.
    issue(ACT_READ, 5, rand_frame(), rand_sel());
    issue(ACT_STATUS, $urandom(), rand_frame(), SEL_FILL);
    issue(ACT_OPEN, 0, rand_frame(), rand_sel());
    issue(ACT_WRITE, $urandom(), '1, rand_sel());
    // Plain burst with extreme frame patterns.
    issue(ACT_OPEN, 3, '0, SEL_TOP);
    issue(ACT_WRITE, '1, '1, rand_sel());
    issue(ACT_WRITE, '0, '0, rand_sel());
    issue(ACT_WRITE, $urandom(), {2{32'hA5A5_5A5A}}, rand_sel());
    // Reopen while a burst is pending: the first burst is abandoned.
    issue(ACT_OPEN, 2, rand_frame(), rand_sel());
    issue(ACT_WRITE, $urandom(), rand_frame(), rand_sel());
    issue(ACT_OPEN, 1, rand_frame(), rand_sel());
    issue(ACT_WRITE, $urandom(), rand_frame(), rand_sel());
    // Flush in the middle of a burst drops only committed frames.
    issue(ACT_OPEN, 2, rand_frame(), rand_sel());
    issue(ACT_WRITE, $urandom(), rand_frame(), rand_sel());
    issue(ACT_FLUSH, $urandom(), rand_frame(), rand_sel());
    issue(ACT_WRITE, $urandom(), rand_frame(), rand_sel());
    // Zero read, then a maximal request clamped to what is stored.
    issue(ACT_READ, 0, rand_frame(), rand_sel());
    issue(ACT_READ, '1, rand_frame(), rand_sel());
    // Oversized opens: full-scale count and one above the capacity.
    issue(ACT_OPEN, '1, rand_frame(), rand_sel());
    issue(ACT_OPEN, CAPACITY_FRAMES + 1, rand_frame(), rand_sel());
    issue(ACT_UNDER, '1, '1, SEL_TOP);
    issue(ACT_STATUS, '0, '0, SEL_STALE);
    issue(ACT_STATUS, $urandom(), rand_frame(), SEL_TOP);
    issue(ACT_SPARE_A, '1, '1, SEL_TOP);
    issue(ACT_SPARE_B, $urandom(), rand_frame(), rand_sel());

    random_traffic(150);
    probe_limits();
    random_traffic(150);

    // Wait out every result, then allow the block to settle.
    wait_all_returned();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** audio_frame_ring_fifo_with_stats_unit: PASSED **");
    end else begin
      $display("** audio_frame_ring_fifo_with_stats_unit: FAILED **");
    end
    $finish;
  end

endmodule
